FILE: rtl/pidfd_pkg.sv
package pidfd_pkg;

  localparam int F     = 16;           // fraction bits
  localparam int ACC_W = 68;           // wide signed working width
  localparam int QW    = 32 + F;       // divider quotient / numerator width
  localparam int CW    = $clog2(QW + 1);

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_OUT_LOW    = 3'd3,
    REG_OUT_HIGH   = 3'd4,
    REG_INTEG_LOW  = 3'd5,
    REG_INTEG_HIGH = 3'd6,
    REG_FILTER_TAU = 3'd7
  } reg_idx_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] top;
    top = v[ACC_W-1:31];
    if (top == '0 || top == '1) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // floor shift of a product by F, then saturate
  function automatic logic signed [31:0] fsat(input logic signed [65:0] v);
    logic signed [ACC_W-1:0] w;
    w = ACC_W'(v);
    return sat32(w >>> F);
  endfunction

  // below low gives low, else above high gives high
  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

FILE: rtl/pid_filtered_derivative.sv
// PID controller step, signed fixed point with F fraction bits (Q16.16).
// Input channel s_*: s_tuser is the action (0 compute, 1 clear); s_tdata
// carries target, measured and step_time. A clear transfer zeroes the
// integral, previous error and previous derivative and yields no result.
// A compute transfer yields one drive value on m_tdata.
// Config port: cfg_we/cfg_addr/cfg_data; user writes only while idle (not enforced).
// Zero step_time gives out_low via S_ZERO once the output register is free.
// A regular compute step runs S_ERR through S_SUM: the shared multiplier
// is used six times and one shift-subtract divider, one quotient bit per
// cycle, runs twice (error slope, then filter alpha).
// Throughput: one item at a time; s_tready is high only while idle.
// A finished result sits in the output register; the next item can be
// taken while it waits, and a new result waits in the final step until the
// register is free, so a stalled receiver only pauses the block.
// Reset: state cleared, registers to their defaults, no result pending.
module pid_filtered_derivative
  import pidfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // [31:0] target, [63:32] measured, [94:64] step_time
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] drive
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_ZERO, S_ERR, S_MP, S_MI, S_T, S_MINC, S_INTEG, S_DLOAD,
    S_DIV1, S_RAW, S_DIV2, S_ALPHA, S_MD1, S_MD2, S_DER, S_MDD, S_SUM
  } state_t;

  state_t state;

  // configuration
  logic signed [31:0] gain_p, gain_i, gain_d, out_low, out_high, integ_low, integ_high;
  logic [30:0]        filter_tau;

  // controller state
  logic signed [31:0] integ_acc, last_error, last_deriv;

  // working registers
  logic signed [31:0] target, measured, err, p_term, tmp, raw, deriv;
  logic [30:0]        dt;
  logic [F:0]         alpha;
  logic               de_neg;
  logic signed [65:0] prod, acc;

  // divider
  logic [QW-1:0] dv_q;
  logic [31:0]   dv_r, dv_den;
  logic [CW-1:0] cnt;
  logic [32:0]   dv_sh;
  logic          dv_ge;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  logic signed [32:0]     diff33, de33;
  logic signed [31:0]     de_sat, inc, integ_next, d_term, drive_next;
  logic [31:0]            de_mag;
  logic signed [QW:0]     q_s;
  logic signed [ACC_W-1:0] w_tmp;

  assign s_tready = (state == S_IDLE);
  assign dv_sh    = {dv_r, dv_q[QW-1]};
  assign dv_ge    = (dv_sh >= {1'b0, dv_den});

  always_comb begin
    diff33     = 33'(target) - 33'(measured);
    de33       = 33'(err) - 33'(last_error);
    de_sat     = sat32(ACC_W'(de33));
    de_mag     = de_sat[31] ? 32'(-33'(de_sat)) : 32'(de_sat);
    inc        = fsat(prod);
    integ_next = clamp32(sat32(ACC_W'(integ_acc) + ACC_W'(inc)), integ_low, integ_high);
    q_s        = {1'b0, dv_q};
    q_s        = de_neg ? -q_s : q_s;
    d_term     = fsat(prod);
    w_tmp      = ACC_W'(p_term) + ACC_W'(integ_acc) + ACC_W'(d_term);
    drive_next = clamp32(sat32(w_tmp), out_low, out_high);
  end

  // gain_d*deriv stays on the multiplier while the result waits in S_SUM
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MP:   begin mul_a = 33'(gain_p); mul_b = 33'(err); end
      S_MI:   begin mul_a = 33'(gain_i); mul_b = 33'(err); end
      S_MINC: begin mul_a = 33'(tmp);    mul_b = signed'({2'b00, dt}); end
      S_MD1:  begin
        mul_a = signed'(33'((F+1)'(1 << F) - alpha));
        mul_b = 33'(last_deriv);
      end
      S_MD2:  begin mul_a = signed'(33'(alpha)); mul_b = 33'(raw); end
      S_MDD, S_SUM: begin mul_a = 33'(gain_d); mul_b = 33'(deriv); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      gain_p     <= 32'sd65536;
      gain_i     <= '0;
      gain_d     <= '0;
      out_low    <= 32'sh8000_0000;
      out_high   <= 32'sh7fff_ffff;
      integ_low  <= 32'sh8000_0000;
      integ_high <= 32'sh7fff_ffff;
      filter_tau <= '0;
      integ_acc  <= '0;
      last_error <= '0;
      last_deriv <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_GAIN_P:     gain_p     <= cfg_data;
          REG_GAIN_I:     gain_i     <= cfg_data;
          REG_GAIN_D:     gain_d     <= cfg_data;
          REG_OUT_LOW:    out_low    <= cfg_data;
          REG_OUT_HIGH:   out_high   <= cfg_data;
          REG_INTEG_LOW:  integ_low  <= cfg_data;
          REG_INTEG_HIGH: integ_high <= cfg_data;
          REG_FILTER_TAU: filter_tau <= cfg_data[30:0];
          default: ;
        endcase
      end

      // in S_ZERO and S_SUM a freed register is refilled below
      if (m_tvalid && m_tready && state != S_ZERO && state != S_SUM) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            target   <= s_tdata[31:0];
            measured <= s_tdata[63:32];
            dt       <= s_tdata[94:64];
            if (s_tuser) begin
              integ_acc  <= '0;
              last_error <= '0;
              last_deriv <= '0;
            end else if (s_tdata[94:64] == '0) begin
              state <= S_ZERO;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_ZERO: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= out_low;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_ERR: begin
          err   <= sat32(ACC_W'(diff33));
          state <= S_MP;
        end
        S_MP:   state <= S_MI;
        S_MI: begin
          p_term <= fsat(prod);
          state  <= S_T;
        end
        S_T: begin
          tmp   <= fsat(prod);
          state <= S_MINC;
        end
        S_MINC: state <= S_INTEG;
        S_INTEG: begin
          integ_acc <= integ_next;
          state     <= S_DLOAD;
        end
        S_DLOAD: begin
          de_neg <= de_sat[31];
          dv_q   <= {de_mag, F'(0)};
          dv_r   <= '0;
          dv_den <= 32'(dt);
          cnt    <= CW'(QW);
          state  <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          dv_r <= dv_ge ? 32'(dv_sh - {1'b0, dv_den}) : dv_sh[31:0];
          dv_q <= {dv_q[QW-2:0], dv_ge};
          cnt  <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= (state == S_DIV1) ? S_RAW : S_ALPHA;
          end
        end
        S_RAW: begin
          raw    <= sat32(ACC_W'(q_s));
          de_neg <= 1'b0;
          dv_q   <= QW'({dt, F'(0)});
          dv_r   <= '0;
          dv_den <= 32'(filter_tau) + 32'(dt);
          cnt    <= CW'(QW);
          state  <= S_DIV2;
        end
        S_ALPHA: begin
          alpha <= dv_q[F:0];
          state <= S_MD1;
        end
        S_MD1:  state <= S_MD2;
        S_MD2: begin
          acc   <= prod;
          state <= S_DER;
        end
        S_DER: begin
          deriv <= sat32((ACC_W'(acc) + ACC_W'(prod)) >>> F);
          state <= S_MDD;
        end
        S_MDD:  state <= S_SUM;
        S_SUM: begin
          if (!m_tvalid || m_tready) begin
            m_tdata    <= drive_next;
            m_tvalid   <= 1'b1;
            last_error <= err;
            last_deriv <= deriv;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pidfd_checker.sv
module pidfd_checker
  import pidfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [95:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_we,
  input logic [2:0]  cfg_addr,
  input logic [31:0] cfg_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a compute transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("ready after compute transfer");

  // a new result only comes from a busy step
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without compute step");

  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind pid_filtered_derivative pidfd_checker u_pidfd_checker (.*);
